// File: hw/rtl/sha1s_pkg.sv
package sha1s_pkg;

    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned HASH_WORDS  = 5;

    localparam logic [6:0] ROUND_LAST    = 7'd79;
    localparam logic [6:0] BLOCK_BYTES   = 7'd64;
    localparam logic [6:0] LEN_FIT_LIMIT = 7'd55;
    localparam logic [3:0] LEN_WORD_HI   = 4'd14;
    localparam logic [2:0] LAST_WORD_IDX = 3'd4;
    localparam logic [7:0] PAD_MARKER    = 8'h80;

    localparam logic [31:0] K_0 = 32'h5a827999;
    localparam logic [31:0] K_1 = 32'h6ed9eba1;
    localparam logic [31:0] K_2 = 32'h8f1bbcdc;
    localparam logic [31:0] K_3 = 32'hca62c1d6;

    typedef logic [HASH_WORDS-1:0][31:0] t_hash;

    localparam t_hash HASH_INIT = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                                   32'hefcdab89, 32'h67452301};

    typedef struct packed {
        logic [6:0] keep;
        logic       mark;
        logic       len;
    } t_pad;

    typedef struct packed {
        logic       load;
        logic       round;
        logic       fold;
        logic       init;
        logic [6:0] t;
    } t_core_ctl;

endpackage

// File: hw/rtl/sha1s_buffer.sv
module sha1s_buffer
    import sha1s_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_wr_en,
    input  logic [5:0]  i_wr_pos,
    input  logic [7:0]  i_wr_data,
    input  logic [3:0]  i_rd_addr,
    input  t_pad        i_pad,
    input  logic [63:0] i_bit_count,
    output logic [31:0] o_word
);

    logic [31:0] r_mem [BLOCK_WORDS];
    logic [31:0] r_rd_data;
    logic [3:0]  r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_pos[5:2]][{~i_wr_pos[1:0], 3'b000} +: 8] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
        r_rd_addr <= i_rd_addr;
    end

    // Bytes past the stored part of the block are replaced by the padding.
    always_comb begin
        logic [6:0] pos;
        o_word = '0;
        for (int j = 0; j < 4; j++) begin
            pos = {1'b0, r_rd_addr, 2'(j)};
            if (pos < i_pad.keep) begin
                o_word[8*(3-j) +: 8] = r_rd_data[8*(3-j) +: 8];
            end else if (i_pad.mark && (pos == i_pad.keep)) begin
                o_word[8*(3-j) +: 8] = PAD_MARKER;
            end
        end
        if (i_pad.len && (r_rd_addr >= LEN_WORD_HI)) begin
            o_word = r_rd_addr[0] ? i_bit_count[31:0] : i_bit_count[63:32];
        end
    end

endmodule

// File: hw/rtl/sha1s_core.sv
module sha1s_core
    import sha1s_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_core_ctl   i_ctl,
    input  logic [31:0] i_word,
    output t_hash       o_hash
);

    t_hash       r_h;
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_w [BLOCK_WORDS];

    logic [31:0] w_sched;
    logic [31:0] w_f;
    logic [31:0] w_k;
    logic [31:0] w_ext;
    logic [31:0] n_a;

    assign w_ext   = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign w_sched = (i_ctl.t < 7'd16) ? i_word : {w_ext[30:0], w_ext[31]};

    always_comb begin
        if (i_ctl.t < 7'd20) begin
            w_f = (r_b & r_c) | (~r_b & r_d);
            w_k = K_0;
        end else if (i_ctl.t < 7'd40) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K_1;
        end else if (i_ctl.t < 7'd60) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            w_k = K_2;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K_3;
        end
    end

    assign n_a = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_k + w_sched;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (i_ctl.round) begin
            r_a <= n_a;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[BLOCK_WORDS-1] <= w_sched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            r_h <= HASH_INIT;
        end else if (i_ctl.fold) begin
            r_h[0] <= r_h[0] + r_a;
            r_h[1] <= r_h[1] + r_b;
            r_h[2] <= r_h[2] + r_c;
            r_h[3] <= r_h[3] + r_d;
            r_h[4] <= r_h[4] + r_e;
        end
    end

    assign o_hash = r_h;

endmodule

// File: hw/rtl/sha1_stream_hasher.sv
// Channel | Dir | tdata             | tuser             | tlast
// s       | in  | data_byte [7:0]   | byte_present      | end_of_message
// m       | out | digest_word[31:0] | word_number [2:0] | last_word
//
// A byte that does not complete a block is stored in the block buffer.
// A completed 64-byte block is compressed in turn: a buffer read, the rounds, a fold.
// An end mark compresses one or two padding blocks in the same way, then
// puts out five words, one per cycle while m_tready is high.
// Reset is synchronous; the block buffer needs no clearing after it.
// A stalled output holds the hasher in its output state until the last word is loaded.
module sha1_stream_hasher
    import sha1s_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tuser,   // [0] byte_present
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] digest_word
    output logic [2:0]  o_m_tuser,   // [2:0] word_number
    output logic        o_m_tlast
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_ROUND,
        S_FOLD,
        S_OUT
    } t_state;

    t_state      r_state;
    logic [5:0]  r_fill;
    logic [63:0] r_bit_count;
    t_pad        r_pad;
    logic        r_fin;
    logic [6:0]  r_t;
    logic [2:0]  r_widx;
    logic        r_m_valid;
    logic [31:0] r_m_data;
    logic [2:0]  r_m_user;
    logic        r_m_last;

    logic        w_accept;
    logic        w_byte;
    logic        w_full;
    logic [6:0]  w_fill_next;
    logic        w_out_load;
    logic [3:0]  w_rd_addr;
    logic [31:0] w_word;
    t_hash       w_hash;
    t_core_ctl   w_ctl;

    assign o_s_tready  = (r_state == S_IDLE);
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_byte      = w_accept && i_s_tuser;
    assign w_full      = w_byte && (r_fill == 6'd63);
    assign w_fill_next = {1'b0, r_fill} + {6'd0, i_s_tuser};
    assign w_out_load  = (r_state == S_OUT) && (!r_m_valid || i_m_tready);
    assign w_rd_addr   = (r_state == S_ROUND) ? (r_t[3:0] + 4'd1) : 4'd0;

    assign w_ctl.load  = (r_state == S_LOAD);
    assign w_ctl.round = (r_state == S_ROUND);
    assign w_ctl.fold  = (r_state == S_FOLD);
    assign w_ctl.init  = w_out_load && (r_widx == LAST_WORD_IDX);
    assign w_ctl.t     = r_t;

    sha1s_buffer u_buffer (
        .i_clk       (i_clk),
        .i_wr_en     (w_byte),
        .i_wr_pos    (r_fill),
        .i_wr_data   (i_s_tdata),
        .i_rd_addr   (w_rd_addr),
        .i_pad       (r_pad),
        .i_bit_count (r_bit_count),
        .o_word      (w_word)
    );

    sha1s_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_word  (w_word),
        .o_hash  (w_hash)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_bit_count <= '0;
            r_fin       <= 1'b0;
            r_t         <= '0;
            r_widx      <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            if (r_m_valid && i_m_tready && !w_out_load) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_byte) begin
                        r_fill      <= r_fill + 6'd1;
                        r_bit_count <= r_bit_count + 64'd8;
                    end
                    if (w_full) begin
                        r_pad   <= '{keep: BLOCK_BYTES, mark: 1'b0, len: 1'b0};
                        r_fin   <= i_s_tlast;
                        r_state <= S_LOAD;
                    end else if (w_accept && i_s_tlast) begin
                        r_pad   <= '{keep: w_fill_next, mark: 1'b1,
                                     len: (w_fill_next <= LEN_FIT_LIMIT)};
                        r_fin   <= 1'b1;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_t     <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_t <= r_t + 7'd1;
                    if (r_t == ROUND_LAST) begin
                        r_state <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    if (r_pad.len) begin
                        r_widx  <= '0;
                        r_state <= S_OUT;
                    end else if (r_fin) begin
                        r_pad   <= '{keep: 7'd0, mark: !r_pad.mark, len: 1'b1};
                        r_state <= S_LOAD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= w_hash[r_widx];
                        r_m_user  <= r_widx;
                        r_m_last  <= (r_widx == LAST_WORD_IDX);
                        r_widx    <= r_widx + 3'd1;
                        if (r_widx == LAST_WORD_IDX) begin
                            r_fill      <= '0;
                            r_bit_count <= '0;
                            r_fin       <= 1'b0;
                            r_state     <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;
    assign o_m_tlast  = r_m_last;

endmodule

// File: hw/rtl/sha1s_checker.sv
module sha1s_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic [2:0]  o_m_tuser,
    input logic        o_m_tlast
);

    // A stalled output transfer keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("output payload changed while stalled");

    // Only the fifth word carries the end mark.
    a_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tlast == (o_m_tuser == 3'd4)))
        else $error("end mark on wrong digest word");

    // Digest words follow one another without gaps in numbering.
    a_word_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=>
            o_m_tvalid && (o_m_tuser == $past(o_m_tuser) + 3'd1))
        else $error("digest words out of sequence");

    // No new input while a digest is still being put out.
    a_no_input_mid_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> !o_s_tready)
        else $error("input accepted during digest output");

endmodule

bind sha1_stream_hasher sha1s_checker u_sha1s_checker (.*);
